[rtl/core/aom_pkg.sv]
package aom_pkg;

  localparam int VALUE_BITS = 32;

  typedef logic signed [VALUE_BITS-1:0] value_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic                         last_in;
  } load_beat_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] out_value;
    logic                         last_out;
  } emit_beat_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_PRIME_N,
    S_PRIME_P,
    S_REFILL,
    S_PICK
  } aom_state_t;

endpackage

[rtl/core/aom_ram.sv]
module aom_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/aom_cmp.sv]
module aom_cmp import aom_pkg::*; (
  input  value_t a,
  input  value_t b,
  output logic   a_le_b
);

  localparam int MAG_W = VALUE_BITS + 1;

  logic [MAG_W-1:0] ext_a;
  logic [MAG_W-1:0] ext_b;
  logic [MAG_W-1:0] mag_a;
  logic [MAG_W-1:0] mag_b;

  // Widen by one bit so the most negative value keeps its magnitude
  assign ext_a = {a[VALUE_BITS-1], a};
  assign ext_b = {b[VALUE_BITS-1], b};
  assign mag_a = a[VALUE_BITS-1] ? (~ext_a + 1'b1) : ext_a;
  assign mag_b = b[VALUE_BITS-1] ? (~ext_b + 1'b1) : ext_b;
  assign a_le_b = (mag_a <= mag_b);

endmodule

[rtl/core/abs_order_merge_of_sorted_array.sv]
// Orders a sorted array of signed values by magnitude.
// Load channel: one beat per element (value, last_in), ascending order expected.
// Beats are taken while load_stall is low; beats beyond MAX_ELEMENTS are dropped, but a
// marked beat still closes the array. The index of the first non-negative
// element is tracked while loading, so no search pass follows.
// After the marked beat load_stall rises and two pointers walk outward from
// that split through a single-read-port element memory. The first result
// beat is registered in S_PICK, after S_PRIME_N and S_PRIME_P read the
// negative head and S_REFILL captures the positive head; every further beat
// alternates a pick step (pick and register the beat) with a refill step
// (refill the consumed side from the memory read port).
// On equal magnitudes the negative element leaves first; last_out marks the
// final beat, after which load_stall drops again.
// Emit channel: a stall holds the output register and its beat; the merge
// waits in its pick step until the register frees.
// Reset (synchronous) returns to loading with an empty array; the element
// memory itself is not cleared.
module abs_order_merge_of_sorted_array import aom_pkg::*; #(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       load_valid,
  output logic       load_stall,
  input  load_beat_t load_beat,
  output logic       emit_valid,
  input  logic       emit_stall,
  output emit_beat_t emit_beat
);

  localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int ADDR_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ELEMENTS);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);
  localparam logic [CNT_W-1:0] TWO_CNT = CNT_W'(2);

  aom_state_t       state;
  aom_state_t       state_next;

  logic [CNT_W-1:0] count;
  logic             split_found;
  logic [CNT_W-1:0] split_idx;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] neg_ptr;
  logic [CNT_W-1:0] pos_ptr;
  logic [CNT_W-1:0] left;
  logic             refill_neg;
  value_t           neg_head;
  value_t           pos_head;

  logic             load_acc;
  logic             store_ok;
  logic             split_first;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W-1:0] count_eff;
  logic [CNT_W-1:0] split_eff;
  logic             emit_ok;
  logic             emit;
  logic             both_sides;
  logic             neg_le;
  logic             take_neg;
  logic [ADDR_W-1:0] rd_addr;
  value_t           rd_data;

  // Load side bookkeeping
  assign load_acc    = load_valid && !load_stall;
  assign store_ok    = load_acc && (count != MAX_CNT);
  assign count_inc   = count + ONE_CNT;
  assign count_eff   = store_ok ? count_inc : count;
  assign split_first = store_ok && !split_found && !load_beat.value[VALUE_BITS-1];
  // With no non-negative element held the split sits at the element count
  assign split_eff   = split_found ? split_idx : (split_first ? count : count_eff);

  // Merge decision
  assign emit_ok    = !emit_valid || !emit_stall;
  assign both_sides = (neg_ptr != '0) && (pos_ptr != n);
  assign take_neg   = both_sides ? neg_le : (neg_ptr != '0);

  aom_cmp u_cmp (
    .a      (neg_head),
    .b      (pos_head),
    .a_le_b (neg_le)
  );

  aom_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_ELEMENTS)
  ) u_store (
    .clk   (clk),
    .we    (store_ok),
    .waddr (count[ADDR_W-1:0]),
    .wdata (load_beat.value),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD: begin
        if (load_acc && load_beat.last_in) begin
          state_next = S_PRIME_N;
        end
      end
      S_PRIME_N: state_next = S_PRIME_P;
      S_PRIME_P: state_next = S_REFILL;
      S_REFILL:  state_next = S_PICK;
      S_PICK: begin
        if (emit_ok) begin
          state_next = (left == ONE_CNT) ? S_LOAD : S_REFILL;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  // Outputs of the sequencer: memory read address, stall, emit strobe
  always_comb begin
    rd_addr    = '0;
    load_stall = 1'b1;
    emit       = 1'b0;
    unique case (state)
      S_LOAD:    load_stall = 1'b0;
      S_PRIME_N: rd_addr = ADDR_W'(neg_ptr - ONE_CNT);
      S_PRIME_P: rd_addr = ADDR_W'(pos_ptr);
      S_REFILL:  rd_addr = '0;
      S_PICK: begin
        emit    = emit_ok;
        // fetch the element behind the one being taken
        rd_addr = take_neg ? ADDR_W'(neg_ptr - TWO_CNT) : ADDR_W'(pos_ptr + ONE_CNT);
      end
      default: rd_addr = '0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_LOAD;
      count       <= '0;
      split_found <= 1'b0;
      split_idx   <= '0;
      emit_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (load_acc) begin
        if (load_beat.last_in) begin
          // array closed: start empty for the next one
          count       <= '0;
          split_found <= 1'b0;
          split_idx   <= '0;
        end else begin
          count <= count_eff;
          if (split_first) begin
            split_found <= 1'b1;
            split_idx   <= count;
          end
        end
      end
      if (emit) begin
        emit_valid <= 1'b1;
      end else if (!emit_stall) begin
        emit_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (load_acc && load_beat.last_in) begin
      n       <= count_eff;
      left    <= count_eff;
      neg_ptr <= split_eff;
      pos_ptr <= split_eff;
    end
    if (state == S_PRIME_P) begin
      neg_head   <= rd_data;
      refill_neg <= 1'b0;
    end
    if (state == S_REFILL) begin
      if (refill_neg) begin
        neg_head <= rd_data;
      end else begin
        pos_head <= rd_data;
      end
    end
    if (emit) begin
      emit_beat.out_value <= take_neg ? neg_head : pos_head;
      emit_beat.last_out  <= (left == ONE_CNT);
      left                <= left - ONE_CNT;
      refill_neg          <= take_neg;
      if (take_neg) begin
        neg_ptr <= neg_ptr - ONE_CNT;
      end else begin
        pos_ptr <= pos_ptr + ONE_CNT;
      end
    end
  end

  // A marked load beat always starts the merge
  a_last_starts_merge: assert property (@(posedge clk) disable iff (rst)
    load_acc && load_beat.last_in |=> state == S_PRIME_N)
    else $error("marked beat did not start the merge");

  // The final pick releases the load side in the next cycle
  a_final_pick_frees_load: assert property (@(posedge clk) disable iff (rst)
    emit && (left == ONE_CNT) |=> !load_stall)
    else $error("load side not released after final beat");

  // Elements still to emit match what the pointers leave
  a_left_matches_ptrs: assert property (@(posedge clk) disable iff (rst)
    state == S_PICK |-> left == neg_ptr + (n - pos_ptr))
    else $error("remaining count out of step with pointers");

  // Pointers stay inside the held array
  a_ptrs_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_PICK |-> (neg_ptr <= n) && (pos_ptr <= n) && (left != '0))
    else $error("merge pointer out of range");

endmodule
